@@ sv/ucitok_pkg.sv @@
// ----------------------------------------------------------------------------
// ucitok_pkg: shared types and constants of the command tokenizer
// request structs, token view, class codes, keyword table and byte tests
// ----------------------------------------------------------------------------
package ucitok_pkg;

	localparam int HELD_CHARS = 10;
	localparam int NUM_KW     = 23;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef logic [4:0] cls_t;

	localparam cls_t CLS_MOVE    = 5'd23;
	localparam cls_t CLS_FEN     = 5'd24;
	localparam cls_t CLS_INT     = 5'd25;
	localparam cls_t CLS_STRING  = 5'd26;
	localparam cls_t CLS_END     = 5'd27;
	localparam cls_t CLS_UNKNOWN = 5'd28;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [3:0] MAX_SLASHES = 4'd15;
	localparam logic [3:0] FEN_SLASHES = 4'd7;

	// keyword text, right-justified, first character in the highest used byte
	localparam logic [8*HELD_CHARS-1:0] KW_TEXT [NUM_KW] = '{
		"position", "moves", "uci", "go", "quit", "debug", "isready",
		"register", "setoption", "ucinewgame", "id", "bestmove", "on", "off",
		"stop", "startpos", "-", "depth", "set", "wtime", "btime", "winc", "binc"
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd8, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd7, 4'd8, 4'd9, 4'd10, 4'd2, 4'd8,
		4'd2, 4'd3, 4'd4, 4'd8, 4'd1, 4'd5, 4'd3, 4'd5, 4'd5, 4'd4, 4'd4
	};

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_line;
	} cmd_t;

	typedef struct packed {
		cls_t       token_class;
		logic [7:0] token_length;
		logic       last_of_line;
	} result_t;

	// token as seen by the classifier
	typedef struct packed {
		logic [7:0]                 len;
		logic [HELD_CHARS-1:0][7:0] chars;
		logic [3:0]                 slashes;
		logic                       all_digits;
		logic                       all_letters;
	} tok_view_t;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_promo(logic [7:0] c);
		return (c == "Q") || (c == "q") || (c == "N") || (c == "n") ||
		       (c == "B") || (c == "b") || (c == "R") || (c == "r");
	endfunction

	function automatic logic kw_hit(tok_view_t t, int k);
		logic                       hit;
		logic [8*HELD_CHARS-1:0]    txt;
		int                         l;
		int                         j;
		txt = KW_TEXT[k];
		l   = int'(KW_LEN[k]);
		hit = (t.len == {4'd0, KW_LEN[k]});
		for (int i = 0; i < HELD_CHARS; i++) begin
			j = (i < l) ? (l - 1 - i) : 0;
			if ((i < l) && (t.chars[i] != txt[j*8 +: 8]))
				hit = 1'b0;
		end
		return hit;
	endfunction

endpackage

@@ sv/ucitok_accum.sv @@
// ----------------------------------------------------------------------------
// ucitok_accum: per-token state
// counts characters, keeps the leading bytes and running flags, clears at
// each token end
// ----------------------------------------------------------------------------
module ucitok_accum #(
	parameter int MAX_TOKEN_LEN = 255
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  ucitok_pkg::cmd_t     cmd,
	output logic                 emit,
	output ucitok_pkg::tok_view_t view
);

	localparam int CountW = $clog2(MAX_TOKEN_LEN + 1);

	logic [CountW-1:0]                      cnt_q, cnt_add, cnt_v;
	logic [ucitok_pkg::HELD_CHARS-1:0][7:0] chars_q, chars_add;
	logic [3:0]                             slash_q, slash_add;
	logic                                   dig_q, dig_add;
	logic                                   alp_q, alp_add;
	logic                                   space;

	assign space = (cmd.char_byte == ucitok_pkg::CH_SPACE);
	assign emit  = space || cmd.end_of_line;

	// state with the current byte appended
	always_comb begin
		cnt_add   = cnt_q;
		chars_add = chars_q;
		slash_add = slash_q;
		for (int i = 0; i < ucitok_pkg::HELD_CHARS; i++) begin
			if (cnt_q == CountW'(i))
				chars_add[i] = cmd.char_byte;
		end
		if (cnt_q != CountW'(MAX_TOKEN_LEN))
			cnt_add = cnt_q + CountW'(1);
		if ((cmd.char_byte == ucitok_pkg::CH_SLASH) && (slash_q != ucitok_pkg::MAX_SLASHES))
			slash_add = slash_q + 4'd1;
		dig_add = dig_q && ucitok_pkg::is_digit(cmd.char_byte);
		alp_add = alp_q && ucitok_pkg::is_alpha(cmd.char_byte);
	end

	// a space closes the token as it stands, any other byte joins it first
	always_comb begin
		cnt_v            = space ? cnt_q : cnt_add;
		view.len         = (32'(cnt_v) > 32'd255) ? 8'hFF : 8'(cnt_v);
		view.chars       = space ? chars_q : chars_add;
		view.slashes     = space ? slash_q : slash_add;
		view.all_digits  = space ? dig_q : dig_add;
		view.all_letters = space ? alp_q : alp_add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			chars_q <= '0;
			slash_q <= '0;
			dig_q   <= 1'b1;
			alp_q   <= 1'b1;
		end else if (step) begin
			if (emit) begin
				cnt_q   <= '0;
				chars_q <= '0;
				slash_q <= '0;
				dig_q   <= 1'b1;
				alp_q   <= 1'b1;
			end else begin
				cnt_q   <= cnt_add;
				chars_q <= chars_add;
				slash_q <= slash_add;
				dig_q   <= dig_add;
				alp_q   <= alp_add;
			end
		end
	end

endmodule

@@ sv/ucitok_classify.sv @@
// ----------------------------------------------------------------------------
// ucitok_classify: token classifier
// keywords first, then move, fen body, integer, string, line end, unknown
// ----------------------------------------------------------------------------
module ucitok_classify (
	input  ucitok_pkg::tok_view_t view,
	output ucitok_pkg::cls_t      token_class
);

	logic                  kw_any;
	ucitok_pkg::cls_t      kw_cls;
	logic                  zeros, pattern, move, lone_eol;

	// keyword strings are distinct, lowest index kept anyway
	always_comb begin
		kw_any = 1'b0;
		kw_cls = '0;
		for (int k = ucitok_pkg::NUM_KW - 1; k >= 0; k--) begin
			if (ucitok_pkg::kw_hit(view, k)) begin
				kw_any = 1'b1;
				kw_cls = ucitok_pkg::cls_t'(k);
			end
		end
	end

	always_comb begin
		zeros = (view.len == 8'd4) &&
		        (view.chars[0] == ucitok_pkg::CH_ZERO) && (view.chars[1] == ucitok_pkg::CH_ZERO) &&
		        (view.chars[2] == ucitok_pkg::CH_ZERO) && (view.chars[3] == ucitok_pkg::CH_ZERO);
		pattern = ucitok_pkg::is_alpha(view.chars[0]) && ucitok_pkg::is_digit(view.chars[1]) &&
		          ucitok_pkg::is_alpha(view.chars[2]) && ucitok_pkg::is_digit(view.chars[3]);
		move = zeros || (pattern && ((view.len == 8'd4) ||
		        ((view.len == 8'd5) && ucitok_pkg::is_promo(view.chars[4]))));
		lone_eol = (view.len == 8'd1) &&
		           ((view.chars[0] == ucitok_pkg::CH_LF) || (view.chars[0] == ucitok_pkg::CH_CR));
	end

	always_comb begin
		priority if (kw_any)
			token_class = kw_cls;
		else if (move)
			token_class = ucitok_pkg::CLS_MOVE;
		else if (view.slashes == ucitok_pkg::FEN_SLASHES)
			token_class = ucitok_pkg::CLS_FEN;
		else if (view.all_digits)
			token_class = ucitok_pkg::CLS_INT;
		else if (view.all_letters)
			token_class = ucitok_pkg::CLS_STRING;
		else if (lone_eol)
			token_class = ucitok_pkg::CLS_END;
		else
			token_class = ucitok_pkg::CLS_UNKNOWN;
	end

endmodule

@@ sv/ucitok_fifo.sv @@
// ----------------------------------------------------------------------------
// ucitok_fifo: result queue
// takes up to two results a cycle, hands out one
// ----------------------------------------------------------------------------
module ucitok_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push0,
	input  logic                push1,
	input  ucitok_pkg::result_t d0,
	input  ucitok_pkg::result_t d1,
	output logic                room,
	output logic                valid,
	input  logic                ready,
	output ucitok_pkg::result_t head
);

	localparam int PtrW = ucitok_pkg::FIFO_PTR_W;

	ucitok_pkg::result_t mem [ucitok_pkg::FIFO_DEPTH];
	logic [PtrW-1:0]     wp_q, rp_q;
	logic [PtrW:0]       cnt_q;
	logic                pop;

	assign valid = (cnt_q != '0);
	assign head  = mem[rp_q];
	assign pop   = valid && ready;
	// two free slots needed whatever the pop does
	assign room  = (32'(cnt_q) <= ucitok_pkg::FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push0)
			mem[wp_q] <= d0;
		if (push1)
			mem[wp_q + PtrW'(1)] <= d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PtrW'(push0) + PtrW'(push1);
			rp_q  <= rp_q + PtrW'(pop);
			cnt_q <= cnt_q + (PtrW+1)'(push0) + (PtrW+1)'(push1) - (PtrW+1)'(pop);
		end
	end

endmodule

@@ sv/uci_command_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// uci_command_tokenizer_top: command line tokenizer
// splits a byte stream at spaces, classifies each token, closes each line
// ----------------------------------------------------------------------------
// the input register holds each accepted byte; once the queue has room for both
// its results they are written to the queue, from whose head they are offered
// throughput: one byte per cycle while the queue has room; a final byte yields
// two results, so a run of final bytes is held back by the single-result port
// the four-entry result queue lets input run on while results wait
// reset: asynchronous, clears the token state, the input stage and the queue
module uci_command_tokenizer_top #(
	parameter int MAX_TOKEN_LEN = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  ucitok_pkg::cmd_t    cmd,
	output logic                tok_valid,
	input  logic                tok_ready,
	output ucitok_pkg::result_t tok
);

	// input register stage
	ucitok_pkg::cmd_t      cmd_s1;
	logic                  valid_s1;
	// processing of the held byte
	logic                  fire;
	logic                  emit;
	logic                  room;
	ucitok_pkg::tok_view_t view;
	ucitok_pkg::cls_t      cls;
	ucitok_pkg::result_t   res_tok, res_end;

	// held byte is processed once the queue has space for both its results
	assign fire      = valid_s1 && room;
	assign cmd_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (cmd_ready)
			valid_s1 <= cmd_valid;
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready)
			cmd_s1 <= cmd;
	end

	ucitok_accum #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_accum (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (fire),
		.cmd   (cmd_s1),
		.emit  (emit),
		.view  (view)
	);

	ucitok_classify u_classify (
		.view       (view),
		.token_class(cls)
	);

	// token result, then the end token on the final byte of a line
	always_comb begin
		res_tok.token_class  = cls;
		res_tok.token_length = view.len;
		res_tok.last_of_line = 1'b0;
		res_end.token_class  = ucitok_pkg::CLS_END;
		res_end.token_length = 8'd0;
		res_end.last_of_line = 1'b1;
	end

	ucitok_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push0 (fire && emit),
		.push1 (fire && cmd_s1.end_of_line),
		.d0    (res_tok),
		.d1    (res_end),
		.room  (room),
		.valid (tok_valid),
		.ready (tok_ready),
		.head  (tok)
	);

endmodule
